>>> hw/rtl/cel_pkg.sv
// Shared types and constants for the cross-entropy loss accumulator.
// No dependencies; the RTL modules and the testbench import this package.
package cel_pkg;

   localparam int unsigned ONE_Q16 = 65536;
   localparam int unsigned LN2_Q16 = 45426;
   localparam logic [63:0] LN2_Q32 = 64'd2977044472;
   localparam int unsigned SUM_BITS = 56;
   localparam int unsigned MEAN_MAX = 786432;

   localparam logic REG_LOSS_MODE   = 1'b0;
   localparam logic REG_CLASS_COUNT = 1'b1;

   localparam logic MODE_CATEGORICAL = 1'b0;
   localparam logic MODE_BINARY      = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic sel;
      logic norm;
      logic interp;
      logic mul;
      logic acc;
      logic sum;
      logic div_start;
      logic div_second;
      logic div_latch;
      logic div_from_count;
      logic out_load;
   } cel_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last;
      logic binary;
      logic div_done;
      logic out_free;
   } cel_status_type;

endpackage

>>> hw/rtl/cel_if.sv
// Valid/ready channel interfaces for request pairs and mean-loss results.
// No dependencies.
interface cel_req_if;
   logic        valid;
   logic        ready;
   logic [16:0] target_value;
   logic [16:0] predicted_value;
   logic        batch_end;
   modport source (output valid, target_value, predicted_value, batch_end, input ready);
   modport sink (input valid, target_value, predicted_value, batch_end, output ready);
endinterface

interface cel_rsp_if;
   logic        valid;
   logic        ready;
   logic [19:0] mean_loss;
   modport source (output valid, mean_loss, input ready);
   modport sink (input valid, mean_loss, output ready);
endinterface

>>> hw/rtl/cel_rom.sv
// Natural-log table ln(1 + i/2^LOG_TABLE_BITS) in Q0.16, two registered read ports.
// Depends on cel_pkg.
module cel_rom import cel_pkg::*; #(
   parameter int LOG_TABLE_BITS = 10
) (
   input  logic                      clock,
   input  logic [LOG_TABLE_BITS-1:0] idx,
   output logic [15:0]               lo_ff,
   output logic [15:0]               hi_ff
);
   localparam int TabN = 1 << LOG_TABLE_BITS;

   // log2 by repeated squaring in Q1.30, scaled by ln2
   function automatic logic [15:0] ln_entry(input int unsigned i);
      logic [63:0] v;
      logic [63:0] lg;
      logic [63:0] prod;
      int          k;
      v  = 64'(TabN + i) << (30 - LOG_TABLE_BITS);
      lg = 64'd0;
      if (v >= 64'h8000_0000) begin
         lg = 64'h1_0000_0000;
      end else begin
         for (k = 0; k < 32; k++) begin
            v  = (v * v) >> 30;
            lg = lg << 1;
            if (v >= 64'h8000_0000) begin
               lg = lg | 64'd1;
               v  = v >> 1;
            end
         end
      end
      prod = lg * LN2_Q32 + (64'd1 << 47);
      return prod[63:48];
   endfunction

   logic [15:0]             tab [TabN+1];
   logic [LOG_TABLE_BITS:0] idx_next;

   for (genvar g = 0; g <= TabN; g++) begin : g_tab
      localparam logic [15:0] Entry = ln_entry(g);
      assign tab[g] = Entry;
   end

   assign idx_next = {1'b0, idx} + (LOG_TABLE_BITS+1)'(1);

   always_ff @(posedge clock) begin
      lo_ff <= tab[{1'b0, idx}];
      hi_ff <= tab[idx_next];
   end
endmodule

>>> hw/rtl/cel_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on cel_pkg.
module cel_div import cel_pkg::*; #(
   parameter int N = 57,
   parameter int D = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [N-1:0] dividend,
   input  logic [D-1:0] divisor,
   output logic         done_ff,
   output logic [N-1:0] quot_ff
);
   localparam int CntBits = $clog2(N + 1);

   logic [N-1:0]       quot_in;
   logic [D-1:0]       rem_ff, rem_in, dsr_ff, dsr_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic               run_ff, run_in, done_in;
   logic [D:0]         trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quot_ff[N-1]};
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in  = D'(trial - {1'b0, dsr_ff});
            quot_in = {quot_ff[N-2:0], 1'b1};
         end else begin
            rem_in  = trial[D-1:0];
            quot_in = {quot_ff[N-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CntBits'(1);
         if (cnt_ff == CntBits'(N - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end
endmodule

>>> hw/rtl/cel_datapath.sv
// Datapath: clamping, log lookup and interpolation, term products, sums, division.
// Depends on cel_pkg, cel_rom, cel_div.
module cel_datapath import cel_pkg::*; #(
   parameter int COUNT_BITS     = 32,
   parameter int LOG_TABLE_BITS = 10
) (
   input  logic           clock,
   input  logic           reset,
   input  cel_cmd_type    cmd,
   output cel_status_type status,
   input  logic           loss_mode,
   input  logic [15:0]    class_count,
   input  logic [16:0]    target_value,
   input  logic [16:0]    predicted_value,
   input  logic           batch_end,
   input  logic           rsp_ready,
   output logic           rsp_valid_ff,
   output logic [19:0]    mean_ff
);
   localparam int FracSh  = 16 - LOG_TABLE_BITS;
   localparam int DivBits = (COUNT_BITS > 16) ? COUNT_BITS : 16;
   localparam int DvdBits = SUM_BITS + 1;
   localparam int IpBits  = 17 + FracSh;

   logic [16:0] y_ff, p_ff, y_c, p_c;
   logic        last_ff;
   logic [16:0] op, wt;
   logic [4:0]  e;
   logic [16:0] m;
   logic [15:0] f;
   logic [LOG_TABLE_BITS-1:0] idx_ff;
   logic [FracSh-1:0]         rem_ff;
   logic [19:0] hi_ff, neg_ff, neg_in;
   logic [15:0] a_q, b_q;
   logic [IpBits-1:0] ip;
   logic [16:0] lm;
   logic [36:0] prod_ff;
   logic [37:0] tacc_ff;
   logic [21:0] term;
   logic [SUM_BITS-1:0] sum_ff, sum_in;
   logic [SUM_BITS:0]   sum_ext;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DivBits-1:0]    div_ff, div_in;
   logic [DvdBits-1:0]    dvd, quot;
   logic [DivBits-1:0]    dsr;
   logic                  div_done;
   logic                  valid_in;
   logic [19:0]           mean_in;

   // input clamping
   always_comb begin
      y_c = (target_value > 17'(ONE_Q16)) ? 17'(ONE_Q16) : target_value;
      p_c = (predicted_value > 17'(ONE_Q16)) ? 17'(ONE_Q16) : predicted_value;
      if (p_c == 17'd0) p_c = 17'd1;
      if (loss_mode == MODE_BINARY && p_c == 17'(ONE_Q16)) p_c = 17'(ONE_Q16 - 1);
   end

   assign op = cmd.sel ? 17'(ONE_Q16) - p_ff : p_ff;
   assign wt = cmd.sel ? 17'(ONE_Q16) - y_ff : y_ff;

   // normalize operand to m in [1,2)
   always_comb begin
      e = 5'd0;
      for (int i = 0; i < 17; i++) begin
         if (op[i]) e = 5'(i);
      end
      m = op << (5'd16 - e);
      f = m[15:0];
   end

   cel_rom #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_rom (
      .clock (clock),
      .idx   (idx_ff),
      .lo_ff (a_q),
      .hi_ff (b_q)
   );

   always_comb begin
      ip = IpBits'(b_q - a_q) * IpBits'(rem_ff) + IpBits'(1 << (FracSh - 1));
      lm = 17'(a_q) + 17'(ip >> FracSh);
      neg_in = (hi_ff > 20'(lm)) ? hi_ff - 20'(lm) : 20'd0;
   end

   assign term    = 22'((tacc_ff + 38'd32768) >> 16);
   assign sum_ext = {1'b0, sum_ff} + (SUM_BITS+1)'(term);

   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (cmd.sum) begin
         sum_in = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
         if (cnt_ff != '1) cnt_in = cnt_ff + COUNT_BITS'(1);
      end
      if (cmd.out_load) begin
         sum_in = '0;
         cnt_in = '0;
      end
   end

   // division operands: first element_count / class_count (categorical mode), then rounded mean
   always_comb begin
      if (cmd.div_second) begin
         dvd = DvdBits'(sum_ff) + DvdBits'(div_ff >> 1);
         dsr = div_ff;
      end else begin
         dvd = DvdBits'(cnt_ff);
         dsr = (class_count == 16'd0) ? DivBits'(1) : DivBits'(class_count);
      end
   end

   cel_div #(.N(DvdBits), .D(DivBits)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  (dsr),
      .done_ff  (div_done),
      .quot_ff  (quot)
   );

   always_comb begin
      div_in = div_ff;
      if (cmd.div_latch) begin
         div_in = (quot == '0) ? DivBits'(1) : DivBits'(quot);
      end else if (cmd.div_from_count) begin
         div_in = (cnt_ff == '0) ? DivBits'(1) : DivBits'(cnt_ff);
      end
   end

   assign mean_in  = (quot > DvdBits'(MEAN_MAX)) ? 20'(MEAN_MAX) : quot[19:0];
   assign valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         y_ff    <= y_c;
         p_ff    <= p_c;
         last_ff <= batch_end;
      end
      if (cmd.norm) begin
         idx_ff <= f[15:FracSh];
         rem_ff <= f[FracSh-1:0];
         hi_ff  <= 20'(5'd16 - e) * 20'(LN2_Q16);
      end
      if (cmd.interp) neg_ff <= neg_in;
      if (cmd.mul) prod_ff <= 37'(wt) * 37'(neg_ff);
      if (cmd.load) begin
         tacc_ff <= '0;
      end else if (cmd.acc) begin
         tacc_ff <= tacc_ff + 38'(prod_ff);
      end
      div_ff <= div_in;
      if (cmd.out_load) mean_ff <= mean_in;
      if (reset) begin
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= valid_in;
      end
   end

   assign status.last     = last_ff;
   assign status.binary   = (loss_mode == MODE_BINARY);
   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || rsp_ready;
endmodule

>>> hw/rtl/cel_ctrl.sv
// Controller state machine sequencing the log, accumulate and divide steps.
// Depends on cel_pkg.
module cel_ctrl import cel_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  cel_status_type status,
   output cel_cmd_type    cmd
);
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_NORM   = 4'd1;
   localparam logic [3:0] ST_ROM    = 4'd2;
   localparam logic [3:0] ST_INTERP = 4'd3;
   localparam logic [3:0] ST_MUL    = 4'd4;
   localparam logic [3:0] ST_ACC    = 4'd5;
   localparam logic [3:0] ST_SUM    = 4'd6;
   localparam logic [3:0] ST_DIV1S  = 4'd7;
   localparam logic [3:0] ST_DIV1W  = 4'd8;
   localparam logic [3:0] ST_DIV2S  = 4'd9;
   localparam logic [3:0] ST_DIV2W  = 4'd10;
   localparam logic [3:0] ST_OUT    = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       sel_ff, sel_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      cmd      = '0;
      cmd.sel  = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               sel_in   = 1'b0;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            cmd.norm = 1'b1;
            state_in = ST_ROM;
         end
         ST_ROM: state_in = ST_INTERP;
         ST_INTERP: begin
            cmd.interp = 1'b1;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc = 1'b1;
            if (status.binary && !sel_ff) begin
               sel_in   = 1'b1;
               state_in = ST_NORM;
            end else begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = status.last ? ST_DIV1S : ST_IDLE;
         end
         ST_DIV1S: begin
            if (status.binary) begin
               cmd.div_from_count = 1'b1;
               state_in           = ST_DIV2S;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV1W;
            end
         end
         ST_DIV1W: begin
            if (status.div_done) begin
               cmd.div_latch = 1'b1;
               state_in      = ST_DIV2S;
            end
         end
         ST_DIV2S: begin
            cmd.div_start  = 1'b1;
            cmd.div_second = 1'b1;
            state_in       = ST_DIV2W;
         end
         ST_DIV2W: begin
            cmd.div_second = 1'b1;
            if (status.div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end
endmodule

>>> hw/rtl/cross_entropy_loss_accumulator.sv
// Top level of the cross-entropy loss accumulator: CSR port, controller, datapath.
// Depends on cel_pkg, cel_if, cel_ctrl, cel_datapath.
//
//   Port       Dir   Handshake            Payload
//   req_chan   in    valid/ready          target_value, predicted_value, batch_end
//   rsp_chan   out   valid/ready          mean_loss (Q4.16, saturated at 12.0)
//   csr_*      in    APB write/read       loss_mode @0x0, class_count @0x4
//
// Sequence: each pair runs one log table pass per logarithm, one in categorical mode
// and two in binary mode (normalize, table read, interpolate, multiply, accumulate),
// then a sum step. A pair with batch_end adds two divisions in categorical mode,
// each producing a 57-bit quotient on the bit-serial divider; binary mode runs one
// division after a divisor-select step. The result is then loaded into the output
// register once it is free. Reset clears loss_sum, element_count, the controller and the result valid.
// A result held on a stalled rsp_chan does not block the next transfer on req_chan;
// only the next batch result waits for the output register to drain.
module cross_entropy_loss_accumulator import cel_pkg::*; #(
   parameter int COUNT_BITS     = 32,
   parameter int LOG_TABLE_BITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   cel_req_if.sink     req_chan,
   cel_rsp_if.source   rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic           mode_ff, mode_in;
   logic [15:0]    class_ff, class_in;
   logic           csr_wr;
   cel_cmd_type    cmd;
   cel_status_type status;

   // CSR block: csr_pready is always high
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      mode_in  = mode_ff;
      class_in = class_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_LOSS_MODE:   mode_in  = csr_pwdata[0];
            REG_CLASS_COUNT: class_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_LOSS_MODE:   csr_prdata = {31'd0, mode_ff};
         REG_CLASS_COUNT: csr_prdata = {16'd0, class_ff};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_BINARY;
         class_ff <= 16'd1;
      end else begin
         mode_ff  <= mode_in;
         class_ff <= class_in;
      end
   end

   // controller owns req ready; datapath owns the result register
   cel_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cel_datapath #(
      .COUNT_BITS     (COUNT_BITS),
      .LOG_TABLE_BITS (LOG_TABLE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .loss_mode       (mode_ff),
      .class_count     (class_ff),
      .target_value    (req_chan.target_value),
      .predicted_value (req_chan.predicted_value),
      .batch_end       (req_chan.batch_end),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid_ff    (rsp_chan.valid),
      .mean_ff         (rsp_chan.mean_loss)
   );
endmodule

>>> tb/cel_tb_pkg.sv
// Predictor for the cross-entropy loss accumulator testbench: log table and per-pair loss.
// Depends on cel_pkg for the fixed-point constants ONE_Q16, LN2_Q16 and LN2_Q32.
package cel_tb_pkg;
   timeunit 1ns;
   timeprecision 1ps;
   import cel_pkg::*;

   localparam int TAB_BITS = 10;
   localparam int TAB_N    = 1 << TAB_BITS;
   localparam int FRAC_SH  = 16 - TAB_BITS;
   localparam logic [55:0] SUM_SAT = {56{1'b1}};
   localparam logic [31:0] CNT_SAT = {32{1'b1}};

   typedef struct packed {
      logic [16:0] target_value;
      logic [16:0] predicted_value;
      logic        batch_end;
   } pair_type;

   // ln(1 + i/TAB_N) in Q0.16, built by bitwise log2 through repeated squaring
   function automatic void fill_log_table(ref logic [31:0] tab [0:TAB_N]);
      logic [63:0] v, lg, prod;
      for (int i = 0; i <= TAB_N; i++) begin
         v = 64'(TAB_N + i) << (30 - TAB_BITS);
         lg = '0;
         if (v >= (64'd1 << 31)) begin
            lg = 64'd1 << 32;
         end else begin
            for (int k = 0; k < 32; k++) begin
               v = (v * v) >> 30;
               lg = lg << 1;
               if (v >= (64'd1 << 31)) begin
                  lg[0] = 1'b1;
                  v = v >> 1;
               end
            end
         end
         prod = lg * LN2_Q32 + (64'd1 << 47);
         tab[i] = 32'(prod >> 48);
      end
   endfunction

   // -ln(p/65536) in Q16.16, p in 1..65536
   function automatic logic [31:0] neg_log_q16(logic [31:0] tab [0:TAB_N], logic [16:0] p);
      int e;
      logic [31:0] m, f, idx, rem, a, b, lm, hi;
      e = 16;
      while (e > 0 && p[e] == 1'b0) e--;
      m = 32'(p) << (16 - e);
      f = m - ONE_Q16;
      idx = f >> FRAC_SH;
      rem = f & ((32'd1 << FRAC_SH) - 1);
      a = tab[idx];
      b = tab[idx + 1];
      lm = a + (((b - a) * rem + (32'd1 << (FRAC_SH - 1))) >> FRAC_SH);
      hi = 32'(16 - e) * LN2_Q16;
      return (hi > lm) ? hi - lm : 32'd0;
   endfunction
endpackage

>>> tb/cel_tb_if.sv
// Channel interfaces come from the RTL (cel_if); this file holds the APB driver helper.
// Depends on nothing; kept separate so the top file stays focused on checking.
interface cel_tb_apb_if (input logic clock);
   timeunit 1ns;
   timeprecision 1ps;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;

   task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask
endinterface

>>> tb/cross_entropy_loss_accumulator_tb.sv
// Self-checking testbench for cross_entropy_loss_accumulator: directed table, then random batches.
// Depends on cel_pkg, cel_if (RTL), cel_tb_pkg and cel_tb_if.
module cross_entropy_loss_accumulator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cel_pkg::*;
   import cel_tb_pkg::*;

   localparam int CLASS_MAX = 65535;
   localparam int DRAIN_CYCLES = 400;   // two serial divisions plus pipeline, with margin
   localparam int HOLD_CYCLES = 600;    // long receiver hold-off

   logic clock = 1'b0;
   logic reset = 1'b1;

   cel_req_if req_chan ();
   cel_rsp_if rsp_chan ();
   cel_tb_apb_if csr (.clock(clock));
   logic [31:0] csr_prdata;
   logic        csr_pready;

   cross_entropy_loss_accumulator dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_psel(csr.psel), .csr_penable(csr.penable), .csr_pwrite(csr.pwrite),
      .csr_paddr(csr.paddr), .csr_pwdata(csr.pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [31:0] log_tab [0:TAB_N];
   logic        mode_q = MODE_BINARY;
   logic [15:0] classes_q = 16'd1;
   logic [55:0] loss_sum_q = '0;
   logic [31:0] pair_count_q = '0;
   logic [19:0] mean_queue [$];

   int  mismatches = 0;
   bit  quiet_tail = 1'b0;   // no idling in the last part
   bit  hold_rsp = 1'b0;     // long receiver hold-off
   bit  stim_done = 1'b0;

   // Update predictor with one accepted pair; push expected mean on batch end.
   task automatic predict_pair(input pair_type it);
      logic [63:0] y, p, term, dv, mean;
      y = (it.target_value > ONE_Q16) ? 64'(ONE_Q16) : 64'(it.target_value);
      p = (it.predicted_value > ONE_Q16) ? 64'(ONE_Q16) : 64'(it.predicted_value);
      term = '0;
      if (mode_q == MODE_CATEGORICAL) begin
         if (y != 0) begin
            if (p < 1) p = 1;
            term = (y * neg_log_q16(log_tab, 17'(p)) + 64'd32768) >> 16;
         end
      end else begin
         if (p < 1) p = 1;
         if (p > ONE_Q16 - 1) p = ONE_Q16 - 1;
         term = (y * neg_log_q16(log_tab, 17'(p))
                 + (ONE_Q16 - y) * neg_log_q16(log_tab, 17'(ONE_Q16 - p)) + 64'd32768) >> 16;
      end
      loss_sum_q = (64'(loss_sum_q) > 64'(SUM_SAT) - term) ? SUM_SAT : 56'(loss_sum_q + term);
      if (pair_count_q != CNT_SAT) pair_count_q++;
      if (it.batch_end) begin
         if (mode_q == MODE_CATEGORICAL)
            dv = pair_count_q / ((classes_q == 0) ? 32'd1 : 32'(classes_q));
         else
            dv = pair_count_q;
         if (dv == 0) dv = 1;
         mean = (64'(loss_sum_q) + (dv >> 1)) / dv;
         if (mean > MEAN_MAX) mean = MEAN_MAX;
         mean_queue.push_back(20'(mean));
         loss_sum_q = '0;
         pair_count_q = '0;
      end
   endtask

   // Result checker: compare each transfer on rsp_chan with oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (mean_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result mean_loss=%0d", rsp_chan.mean_loss);
         end else begin
            logic [19:0] want;
            want = mean_queue.pop_front();
            if (rsp_chan.mean_loss !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mean_loss mismatch: expected %0d actual %0d", want, rsp_chan.mean_loss);
            end
         end
      end
   end

   // Receiver: random stall bursts, plus an explicit long hold-off counted here.
   initial begin
      int gap;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Send one pair, with optional idle burst first; returns after the transfer.
   task automatic send_pair(input pair_type it);
      int gap;
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.target_value <= it.target_value;
      req_chan.predicted_value <= it.predicted_value;
      req_chan.batch_end <= it.batch_end;
      do @(posedge clock); while (!req_chan.ready);
      predict_pair(it);
   endtask

   task automatic set_mode(input logic mode, input logic [15:0] classes);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (mean_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr.write_reg(3'(4 * REG_LOSS_MODE), 32'(mode));
      csr.write_reg(3'(4 * REG_CLASS_COUNT), 32'(classes));
      mode_q = mode;
      classes_q = classes;
   endtask

   function automatic logic [16:0] rand_prob();
      case ($urandom_range(0, 9))
         0: return 17'd0;
         1: return 17'(ONE_Q16);
         2: return 17'($urandom_range(ONE_Q16 + 1, 131071));
         3: return 17'($urandom_range(1, 64));
         default: return 17'($urandom_range(0, ONE_Q16));
      endcase
   endfunction

   // Directed rows: fields and, where obvious, the expected mean (-1 = predictor only).
   typedef struct {
      logic        mode;
      logic [15:0] classes;
      pair_type    it;
      int          want;
   } row_type;

   row_type rows [] = '{
      // binary, reset config: perfect prediction at the clamp gives ~0 loss
      '{MODE_BINARY, 16'd1, '{17'd65536, 17'd65536, 1'b1}, -1},
      '{MODE_BINARY, 16'd1, '{17'd0, 17'd0, 1'b1}, -1},
      // worst-case wrong prediction: about 11.09 per pair
      '{MODE_BINARY, 16'd1, '{17'd65536, 17'd0, 1'b1}, -1},
      // over-range fields clamp to 1.0
      '{MODE_BINARY, 16'd1, '{17'h1FFFF, 17'h1FFFF, 1'b1}, -1},
      '{MODE_BINARY, 16'd1, '{17'd32768, 17'd32768, 1'b0}, -1},
      '{MODE_BINARY, 16'd1, '{17'd32768, 17'd1, 1'b1}, -1},
      '{MODE_BINARY, 16'd1, '{17'h0AAAA, 17'h15555, 1'b1}, -1},
      // categorical: zero target skipped, loss of exact prediction is 0
      '{MODE_CATEGORICAL, 16'd1, '{17'd0, 17'd0, 1'b1}, 0},
      '{MODE_CATEGORICAL, 16'd1, '{17'd65536, 17'd65536, 1'b1}, 0},
      '{MODE_CATEGORICAL, 16'd1, '{17'd65536, 17'd0, 1'b1}, -1},
      '{MODE_CATEGORICAL, 16'd1, '{17'h15555, 17'h0AAAA, 1'b1}, -1},
      // class count 3: 3 pairs make one sample
      '{MODE_CATEGORICAL, 16'd3, '{17'd0, 17'd100, 1'b0}, -1},
      '{MODE_CATEGORICAL, 16'd3, '{17'd65536, 17'd1, 1'b0}, -1},
      '{MODE_CATEGORICAL, 16'd3, '{17'd0, 17'd9, 1'b1}, -1},
      // quotient zero acts as one; big class count
      '{MODE_CATEGORICAL, 16'(CLASS_MAX), '{17'd65536, 17'd1, 1'b0}, -1},
      '{MODE_CATEGORICAL, 16'(CLASS_MAX), '{17'd65536, 17'd1, 1'b1}, -1},
      // class count zero acts as one
      '{MODE_CATEGORICAL, 16'd0, '{17'd65536, 17'd16384, 1'b1}, -1}
   };

   initial begin
      pair_type it;
      int batch_len;
      fill_log_table(log_tab);
      req_chan.valid = 1'b0;
      req_chan.target_value = '0;
      req_chan.predicted_value = '0;
      req_chan.batch_end = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (rows[i]) begin
         if (rows[i].mode != mode_q || rows[i].classes != classes_q)
            set_mode(rows[i].mode, rows[i].classes);
         if (rows[i].want >= 0 && rows[i].it.batch_end) begin
            send_pair(rows[i].it);
            if (mean_queue[$] !== 20'(rows[i].want)) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("directed row %0d: table %0d predictor %0d",
                           i, rows[i].want, mean_queue[$]);
            end
         end else begin
            send_pair(rows[i].it);
         end
      end

      // random batches across several settings; long receiver hold-off in the first one
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_mode(MODE_BINARY, 16'd1);
            1: set_mode(MODE_CATEGORICAL, 16'd4);
            2: set_mode(MODE_CATEGORICAL, 16'(CLASS_MAX));
            3: set_mode(MODE_CATEGORICAL, 16'($urandom_range(1, 10)));
            4: set_mode(MODE_BINARY, 16'($urandom_range(0, CLASS_MAX)));
            default: set_mode(MODE_CATEGORICAL, 16'd2);
         endcase
         if (phase == 5) quiet_tail = 1'b1;
         if (phase == 0) hold_rsp = 1'b1;
         for (int n = 0; n < 150; ) begin
            batch_len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 8);
            for (int k = 0; k < batch_len; k++) begin
               it.target_value = rand_prob();
               it.predicted_value = rand_prob();
               it.batch_end = (k == batch_len - 1);
               send_pair(it);
               n++;
            end
         end
      end
      req_chan.valid <= 1'b0;
      stim_done = 1'b1;
   end

   // End of run: drain expectations, then wait out latency.
   initial begin
      wait (stim_done);
      while (mean_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && mean_queue.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Hard limit: ~1000 pairs with their log passes, divisions and stalls stay well under this.
   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end
endmodule

>>> filelist.f
hw/rtl/cel_pkg.sv
hw/rtl/cel_if.sv
hw/rtl/cel_rom.sv
hw/rtl/cel_div.sv
hw/rtl/cel_datapath.sv
hw/rtl/cel_ctrl.sv
hw/rtl/cross_entropy_loss_accumulator.sv
tb/cel_tb_pkg.sv
tb/cel_tb_if.sv
tb/cross_entropy_loss_accumulator_tb.sv
